// ===== sv/rlid_pkg.sv =====
// ----------------------------------------------------------------------------
// rlid_pkg
// Shared types and constants for the pitched run-length image decoder.
// ----------------------------------------------------------------------------
package rlid_pkg;

  localparam int          OFFSET_BITS_DEF = 24;
  localparam int          OUT_OFFSET_W    = 24;
  localparam int          PITCH_W         = 16;
  localparam int          DIM_W           = 16;
  localparam int          RUN_W           = 6;
  localparam int          CFG_ADDR_W      = 3;
  localparam int          CFG_DATA_W      = 32;

  localparam logic [7:0]  RUN_BASE        = 8'hC0;
  localparam logic [7:0]  RUN_FIRST       = 8'hC1;
  localparam logic [15:0] PITCH_RESET     = 16'd320;

  // register index, taken from paddr[CFG_ADDR_W-1:2]
  localparam logic [CFG_ADDR_W-3:0] REG_ROW_PITCH = '0;

  // header byte positions
  localparam logic [1:0] HDR_WIDTH_LO  = 2'd0;
  localparam logic [1:0] HDR_WIDTH_HI  = 2'd1;
  localparam logic [1:0] HDR_HEIGHT_LO = 2'd2;
  localparam logic [1:0] HDR_HEIGHT_HI = 2'd3;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_DATA,
    ST_RUNVAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic hdr_wr;    // store a header byte
    logic run_wr;    // load run length from a marker
    logic pix_wr;    // load pixel value and repeat count
    logic pix_run;   // repeat count from run length (else one)
    logic emit;      // produce one pixel into the output register
  } cmd_t;

  typedef struct packed {
    logic is_marker;
    logic hdr_last;
    logic hdr_empty;
    logic cnt_last;
    logic img_done;
    logic can_load;
  } sts_t;

endpackage

// ===== sv/rlid_regs.sv =====
// ----------------------------------------------------------------------------
// rlid_regs
// Configuration register file: row pitch, written over the APB-style port.
// ----------------------------------------------------------------------------
module rlid_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rlid_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rlid_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rlid_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [rlid_pkg::PITCH_W-1:0]     row_pitch
);

  logic [rlid_pkg::PITCH_W-1:0]    pitch_r;
  logic [rlid_pkg::PITCH_W-1:0]    pitch_nxt;
  logic [rlid_pkg::CFG_ADDR_W-3:0] reg_idx;
  logic                            sel_pitch;

  assign reg_idx   = paddr[rlid_pkg::CFG_ADDR_W-1:2];
  assign sel_pitch = (reg_idx == rlid_pkg::REG_ROW_PITCH);
  assign pready    = 1'b1;

  always_comb begin
    pitch_nxt = pitch_r;
    if (psel && penable && pwrite && sel_pitch) begin
      pitch_nxt = pwdata[rlid_pkg::PITCH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_pitch) begin
      prdata = rlid_pkg::CFG_DATA_W'(pitch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= rlid_pkg::PITCH_RESET;
    end else begin
      pitch_r <= pitch_nxt;
    end
  end

  assign row_pitch = pitch_r;

endmodule

// ===== sv/rlid_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlid_ctrl
// Decode state machine: header, data, run value and pixel emission phases.
// ----------------------------------------------------------------------------
module rlid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlid_pkg::sts_t sts,
  output rlid_pkg::cmd_t cmd
);

  rlid_pkg::state_t state_r;
  rlid_pkg::state_t state_nxt;
  logic             accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlid_pkg::ST_HEADER: begin
        if (accept && sts.hdr_last && !sts.hdr_empty) begin
          state_nxt = rlid_pkg::ST_DATA;
        end
      end
      rlid_pkg::ST_DATA: begin
        if (accept) begin
          state_nxt = sts.is_marker ? rlid_pkg::ST_RUNVAL : rlid_pkg::ST_EMIT;
        end
      end
      rlid_pkg::ST_RUNVAL: begin
        if (accept) begin
          state_nxt = rlid_pkg::ST_EMIT;
        end
      end
      rlid_pkg::ST_EMIT: begin
        if (sts.can_load) begin
          if (sts.img_done) begin
            state_nxt = rlid_pkg::ST_HEADER;
          end else if (sts.cnt_last) begin
            state_nxt = rlid_pkg::ST_DATA;
          end
        end
      end
      default: state_nxt = rlid_pkg::ST_HEADER;
    endcase
  end

  always_comb begin
    in_stall    = 1'b0;
    cmd         = '0;
    case (state_r)
      rlid_pkg::ST_HEADER: begin
        cmd.hdr_wr = in_valid;
      end
      rlid_pkg::ST_DATA: begin
        cmd.run_wr = in_valid && sts.is_marker;
        cmd.pix_wr = in_valid && !sts.is_marker;
      end
      rlid_pkg::ST_RUNVAL: begin
        cmd.pix_wr  = in_valid;
        cmd.pix_run = 1'b1;
      end
      rlid_pkg::ST_EMIT: begin
        in_stall = 1'b1;
        cmd.emit = sts.can_load;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlid_pkg::ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/rlid_dp.sv =====
// ----------------------------------------------------------------------------
// rlid_dp
// Datapath: header fields, column/row/base counters, run count and the
// output register.
// ----------------------------------------------------------------------------
module rlid_dp #(
  parameter int OFFSET_BITS = rlid_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [7:0]                         in_data_byte,
  input  logic [rlid_pkg::PITCH_W-1:0]       row_pitch,
  input  rlid_pkg::cmd_t                     cmd,
  output rlid_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_pixel_value,
  output logic [rlid_pkg::OUT_OFFSET_W-1:0]  out_write_offset,
  output logic                               out_last_of_run,
  output logic                               out_image_done
);

  localparam int DW = rlid_pkg::DIM_W;
  localparam int RW = rlid_pkg::RUN_W;

  logic [1:0]             hdr_idx_r,  hdr_idx_nxt;
  logic [DW-1:0]          width_r,    width_nxt;
  logic [DW-1:0]          height_r,   height_nxt;
  logic [DW-1:0]          col_r,      col_nxt;
  logic [DW-1:0]          row_r,      row_nxt;
  logic [OFFSET_BITS-1:0] base_r,     base_nxt;
  logic [RW-1:0]          run_len_r,  run_len_nxt;
  logic [RW-1:0]          cnt_r,      cnt_nxt;
  logic [7:0]             pix_r,      pix_nxt;
  logic                   oval_r,     oval_nxt;
  logic [7:0]             opix_r,     opix_nxt;
  logic [rlid_pkg::OUT_OFFSET_W-1:0] ooff_r, ooff_nxt;
  logic                   olast_r,    olast_nxt;
  logic                   odone_r,    odone_nxt;

  logic [DW-1:0]          col_inc;
  logic [DW-1:0]          row_inc;
  logic                   row_wrap;
  logic                   done;
  logic [OFFSET_BITS-1:0] offset;
  logic [7:0]             run_diff;

  assign col_inc  = col_r + 1'b1;
  assign row_inc  = row_r + 1'b1;
  assign row_wrap = (col_inc >= width_r);
  assign done     = row_wrap && (row_inc >= height_r);
  assign offset   = base_r + OFFSET_BITS'(col_r);
  assign run_diff = in_data_byte - rlid_pkg::RUN_BASE;

  assign sts.is_marker = (in_data_byte >= rlid_pkg::RUN_FIRST);
  assign sts.hdr_last  = (hdr_idx_r == rlid_pkg::HDR_HEIGHT_HI);
  assign sts.hdr_empty = (width_r == '0) || ({in_data_byte, height_r[7:0]} == '0);
  assign sts.cnt_last  = (cnt_r == RW'(1));
  assign sts.img_done  = done;
  assign sts.can_load  = !oval_r || !out_stall;

  always_comb begin
    hdr_idx_nxt = hdr_idx_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    base_nxt    = base_r;
    run_len_nxt = run_len_r;
    cnt_nxt     = cnt_r;
    pix_nxt     = pix_r;
    oval_nxt    = oval_r && out_stall;
    opix_nxt    = opix_r;
    ooff_nxt    = ooff_r;
    olast_nxt   = olast_r;
    odone_nxt   = odone_r;

    if (cmd.hdr_wr) begin
      hdr_idx_nxt = hdr_idx_r + 1'b1;
      case (hdr_idx_r)
        rlid_pkg::HDR_WIDTH_LO:  width_nxt  = {width_r[15:8], in_data_byte};
        rlid_pkg::HDR_WIDTH_HI:  width_nxt  = {in_data_byte, width_r[7:0]};
        rlid_pkg::HDR_HEIGHT_LO: height_nxt = {height_r[15:8], in_data_byte};
        rlid_pkg::HDR_HEIGHT_HI: begin
          height_nxt  = {in_data_byte, height_r[7:0]};
          col_nxt     = '0;
          row_nxt     = '0;
          base_nxt    = '0;
          run_len_nxt = '0;
        end
        default: hdr_idx_nxt = hdr_idx_r;
      endcase
    end

    if (cmd.run_wr) begin
      run_len_nxt = run_diff[RW-1:0];
    end

    if (cmd.pix_wr) begin
      pix_nxt = in_data_byte;
      cnt_nxt = cmd.pix_run ? run_len_r : RW'(1);
      if (cmd.pix_run) begin
        run_len_nxt = '0;
      end
    end

    if (cmd.emit) begin
      cnt_nxt   = cnt_r - 1'b1;
      oval_nxt  = 1'b1;
      opix_nxt  = pix_r;
      ooff_nxt  = rlid_pkg::OUT_OFFSET_W'(offset);
      olast_nxt = sts.cnt_last || done;
      odone_nxt = done;
      if (row_wrap) begin
        col_nxt  = '0;
        row_nxt  = row_inc;
        base_nxt = base_r + OFFSET_BITS'(row_pitch);
      end else begin
        col_nxt  = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r <= '0;
      width_r   <= '0;
      height_r  <= '0;
      col_r     <= '0;
      row_r     <= '0;
      base_r    <= '0;
      run_len_r <= '0;
      cnt_r     <= '0;
      oval_r    <= 1'b0;
    end else begin
      hdr_idx_r <= hdr_idx_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      base_r    <= base_nxt;
      run_len_r <= run_len_nxt;
      cnt_r     <= cnt_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r   <= pix_nxt;
    opix_r  <= opix_nxt;
    ooff_r  <= ooff_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid        = oval_r;
  assign out_pixel_value  = opix_r;
  assign out_write_offset = ooff_r;
  assign out_last_of_run  = olast_r;
  assign out_image_done   = odone_r;

endmodule

// ===== sv/rle_image_decoder_pitched.sv =====
// ----------------------------------------------------------------------------
// rle_image_decoder_pitched
// PCX-style run-length image decoder with pitched destination offsets.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_data_byte
//   out_     output     out_valid/out_stall out_pixel_value, out_write_offset,
//                                           out_last_of_run, out_image_done
//   cfg      input      psel/penable/pready paddr, pwdata, prdata (row_pitch)
//
// Header and marker bytes are accepted directly; a literal is accepted, then
// emitted. A run's value byte is accepted, then the emit step yields one pixel
// per cycle through the single output register, and in_stall is high meanwhile.
// out_stall holds back the emit phase while a pixel waits; bytes are still taken
// while a finished pixel waits in the output register.
// Synchronous reset returns the decoder to header and sets row_pitch to 320.
// ----------------------------------------------------------------------------
module rle_image_decoder_pitched #(
  parameter int OFFSET_BITS = rlid_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_pixel_value,
  output logic [rlid_pkg::OUT_OFFSET_W-1:0]  out_write_offset,
  output logic                               out_last_of_run,
  output logic                               out_image_done,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rlid_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rlid_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rlid_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [rlid_pkg::PITCH_W-1:0] row_pitch;
  rlid_pkg::cmd_t               cmd;
  rlid_pkg::sts_t               sts;

  rlid_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_pitch (row_pitch)
  );

  rlid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlid_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .row_pitch        (row_pitch),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_write_offset (out_write_offset),
    .out_last_of_run  (out_last_of_run),
    .out_image_done   (out_image_done)
  );

endmodule

// ===== sv/rlid_checker.sv =====
// ----------------------------------------------------------------------------
// rlid_checker
// Port-level checks for the run-length image decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlid_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [7:0]                         in_data_byte,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [7:0]                         out_pixel_value,
  input logic [rlid_pkg::OUT_OFFSET_W-1:0]  out_write_offset,
  input logic                               out_last_of_run,
  input logic                               out_image_done,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [rlid_pkg::CFG_ADDR_W-1:0]    paddr,
  input logic [rlid_pkg::CFG_DATA_W-1:0]    pwdata,
  input logic [rlid_pkg::CFG_DATA_W-1:0]    prdata,
  input logic                               pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_value)
      && $stable(out_write_offset) && $stable(out_last_of_run)
      && $stable(out_image_done))
    else $error("stalled transaction changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_last_of_run)
    else $error("image end without last_of_run");

  a_next_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("input taken in the middle of a run");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind rle_image_decoder_pitched rlid_checker u_rlid_checker (.*);
